### sv/dbb_pkg.sv
// shared types, widths and constants for the dilated 3x3 box blur
// no dependencies
`default_nettype none

package dbb_pkg;

  localparam int MAX_SIZE_DEF = 1024;
  localparam int CH_W         = 16;
  localparam int PIX_W        = 3 * CH_W;
  localparam int CFG_W        = 11;
  localparam int SUM_W        = 20;
  localparam int CNT_W        = 4;
  localparam int RCP_SHIFT    = 24;
  localparam int RCP_W        = RCP_SHIFT + 1;
  localparam int PROD_W       = SUM_W + RCP_W;
  localparam int QDEPTH       = 4;
  localparam int QL_W         = $clog2(QDEPTH + 1);

  localparam logic [CFG_W-1:0] FRAME_SIZE_RST = CFG_W'(64);

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // reciprocals rounded up, exact for sums below 2^20
  localparam logic [RCP_W-1:0] RCP_1 = RCP_W'(1 << RCP_SHIFT);
  localparam logic [RCP_W-1:0] RCP_2 = RCP_W'(1 << (RCP_SHIFT - 1));
  localparam logic [RCP_W-1:0] RCP_3 = RCP_W'(((1 << RCP_SHIFT) + 2) / 3);
  localparam logic [RCP_W-1:0] RCP_4 = RCP_W'(1 << (RCP_SHIFT - 2));
  localparam logic [RCP_W-1:0] RCP_6 = RCP_W'(((1 << RCP_SHIFT) + 5) / 6);
  localparam logic [RCP_W-1:0] RCP_9 = RCP_W'(((1 << RCP_SHIFT) + 8) / 9);

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    sum_t             red;
    sum_t             green;
    sum_t             blue;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } acc_t;

  typedef struct packed {
    logic             valid;
    logic [QL_W-1:0]  level;
  } q_stat_t;

  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RCP_W-1:0] r;
    case (cnt)
      CNT_W'(2): r = RCP_2;
      CNT_W'(3): r = RCP_3;
      CNT_W'(4): r = RCP_4;
      CNT_W'(6): r = RCP_6;
      CNT_W'(9): r = RCP_9;
      default:   r = RCP_1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/dbb_front.sv
// front end: frame counters, classification, two line stores, window and sums
// depends on dbb_pkg
`default_nettype none

module dbb_front
  import dbb_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_mode,
  input  wire chan_t            in_red,
  input  wire chan_t            in_green,
  input  wire chan_t            in_blue,
  input  wire q_stat_t          q_stat,
  output logic                  push_valid,
  output acc_t                  push_data
);

  localparam int N_W    = $clog2(MAX_SIZE + 1);
  localparam int COL_W  = $clog2(MAX_SIZE);
  localparam int ROW_W  = $clog2(MAX_SIZE + 3);
  localparam int LEAD_W = $clog2(2 * MAX_SIZE + 3);
  localparam int ADDR_W = COL_W + 1;
  localparam int LDEPTH = 1 << ADDR_W;

  logic [CFG_W-1:0]  frame_size_r;
  logic [N_W-1:0]    n;
  logic [ROW_W-1:0]  in_row_r;
  logic [COL_W-1:0]  in_col_r;
  logic [COL_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic [LEAD_W-1:0] lead_r;
  logic [LEAD_W-1:0] lead_tgt;
  logic              draining, lead_hit, accept, push, emit, last;
  logic              col_end, up, down, left, right;
  logic [ADDR_W-1:0] addr;
  logic [PIX_W-1:0]  px;

  // line stores: each delays the stream by two rows
  logic [PIX_W-1:0]  mem0 [LDEPTH];
  logic [PIX_W-1:0]  mem1 [LDEPTH];
  logic [PIX_W-1:0]  mem0_rd_r, mem1_rd_r;

  logic              s1_v_r, s1_emit_r, s1_last_r;
  logic [3:0]        s1_mask_r;
  logic [PIX_W-1:0]  s1_px_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              s2_v_r, s2_last_r;
  logic [3:0]        s2_mask_r;

  // window: [column age][row tap], tap 0 newest row, tap 2 four rows back
  logic [PIX_W-1:0]  win_r [5][3];

  logic [2:0]        col_ok, row_ok;
  logic [1:0]        rc, cc;
  logic [PIX_W-1:0]  ctr;
  sum_t              sum_red, sum_green, sum_blue;

  assign cfg_ready = rst_n;

  always_comb begin
    if (frame_size_r == '0) begin
      n = N_W'(1);
    end else if (32'(frame_size_r) > MAX_SIZE) begin
      n = N_W'(MAX_SIZE);
    end else begin
      n = N_W'(frame_size_r);
    end
  end

  assign lead_tgt = LEAD_W'({n, 1'b0}) + LEAD_W'(2);
  assign lead_hit = (lead_r == lead_tgt);
  assign draining = (32'(in_row_r) >= 32'(n));
  assign in_ready = rst_n &
                    ((32'(q_stat.level) + 32'(s1_v_r & s1_emit_r) + 32'(s2_v_r)) < QDEPTH);
  assign accept   = in_valid & in_ready;
  assign push     = accept & ((in_mode == MODE_PIXEL) ? !draining : draining);
  assign emit     = push & (draining | lead_hit);
  assign col_end  = (32'(in_col_r) + 1 == 32'(n));
  assign last     = emit & (32'(out_row_r) + 1 == 32'(n)) & (32'(out_col_r) + 1 == 32'(n));
  assign up       = (32'(out_row_r) >= 2);
  assign down     = (32'(out_row_r) + 2 < 32'(n));
  assign left     = (32'(out_col_r) >= 2);
  assign right    = (32'(out_col_r) + 2 < 32'(n));
  assign addr     = {in_row_r[0], in_col_r};
  assign px       = {in_red, in_green, in_blue};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r <= FRAME_SIZE_RST;
      in_row_r     <= '0;
      in_col_r     <= '0;
      out_row_r    <= '0;
      out_col_r    <= '0;
      lead_r       <= '0;
    end else if (cfg_valid) begin
      frame_size_r <= cfg_data;
      in_row_r     <= '0;
      in_col_r     <= '0;
      out_row_r    <= '0;
      out_col_r    <= '0;
      lead_r       <= '0;
    end else if (last) begin
      in_row_r     <= '0;
      in_col_r     <= '0;
      out_row_r    <= '0;
      out_col_r    <= '0;
      lead_r       <= '0;
    end else begin
      if (push) begin
        if (col_end) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + ROW_W'(1);
        end else begin
          in_col_r <= in_col_r + COL_W'(1);
        end
        if (!lead_hit) begin
          lead_r <= lead_r + LEAD_W'(1);
        end
      end
      if (emit) begin
        if (32'(out_col_r) + 1 == 32'(n)) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + COL_W'(1);
        end else begin
          out_col_r <= out_col_r + COL_W'(1);
        end
      end
    end
  end

  // second store is fed from the first in the cycle after each push, at the held address
  always_ff @(posedge clk) begin
    if (push) begin
      mem0[addr] <= px;
      mem0_rd_r  <= mem0[addr];
      mem1_rd_r  <= mem1[addr];
    end
    if (s1_v_r) begin
      mem1[s1_addr_r] <= mem0_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_emit_r <= 1'b0;
      s2_v_r    <= 1'b0;
    end else begin
      s1_v_r    <= push;
      s1_emit_r <= emit;
      s2_v_r    <= s1_v_r & s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      s1_px_r   <= px;
      s1_addr_r <= addr;
      s1_mask_r <= {up, down, left, right};
      s1_last_r <= last;
    end
    s2_mask_r <= s1_mask_r;
    s2_last_r <= s1_last_r;
    if (s1_v_r) begin
      win_r[0][0] <= s1_px_r;
      win_r[0][1] <= mem0_rd_r;
      win_r[0][2] <= mem1_rd_r;
      for (int k = 1; k < 5; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[k][j] <= win_r[k-1][j];
        end
      end
    end
  end

  // mask order: up, down, left, right
  assign col_ok = {s2_mask_r[1], 1'b1, s2_mask_r[0]};
  assign row_ok = {s2_mask_r[3], 1'b1, s2_mask_r[2]};
  assign rc     = 2'd1 + {1'b0, s2_mask_r[3]} + {1'b0, s2_mask_r[2]};
  assign cc     = 2'd1 + {1'b0, s2_mask_r[1]} + {1'b0, s2_mask_r[0]};

  // for frames one or two pixels wide the centre sits elsewhere in the window
  always_comb begin
    if (n == N_W'(1)) begin
      ctr = win_r[1][0];
    end else if (n == N_W'(2)) begin
      ctr = win_r[4][0];
    end else begin
      ctr = win_r[2][1];
    end
  end

  always_comb begin
    sum_red   = SUM_W'(ctr[2*CH_W +: CH_W]);
    sum_green = SUM_W'(ctr[CH_W +: CH_W]);
    sum_blue  = SUM_W'(ctr[0 +: CH_W]);
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (col_ok[k] && row_ok[j] && !(k == 1 && j == 1)) begin
          sum_red   = sum_red   + SUM_W'(win_r[2*k][j][2*CH_W +: CH_W]);
          sum_green = sum_green + SUM_W'(win_r[2*k][j][CH_W +: CH_W]);
          sum_blue  = sum_blue  + SUM_W'(win_r[2*k][j][0 +: CH_W]);
        end
      end
    end
  end

  assign push_valid      = s2_v_r;
  assign push_data.red   = sum_red;
  assign push_data.green = sum_green;
  assign push_data.blue  = sum_blue;
  assign push_data.cnt   = CNT_W'(rc) * CNT_W'(cc);
  assign push_data.last  = s2_last_r;

endmodule

`default_nettype wire

### sv/dbb_queue.sv
// short queue of channel sums between the front and back ends
// depends on dbb_pkg
`default_nettype none

module dbb_queue
  import dbb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  input  wire acc_t push_data,
  input  wire logic pop,
  output q_stat_t   q_stat,
  output acc_t      head
);

  localparam int PTR_W = $clog2(QDEPTH);

  acc_t             slot_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QL_W-1:0]  level_r;
  logic             do_pop;

  // front end never pushes into a full queue, it holds credit for that
  assign do_pop       = pop & (level_r != '0);
  assign q_stat.valid = (level_r != '0);
  assign q_stat.level = level_r;
  assign head         = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push_valid && !do_pop) begin
        level_r <= level_r + QL_W'(1);
      end else if (!push_valid && do_pop) begin
        level_r <= level_r - QL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### sv/dbb_back.sv
// back end: divide the sums by the tap count and hold the result transaction
// depends on dbb_pkg
`default_nettype none

module dbb_back
  import dbb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire q_stat_t q_stat,
  input  wire acc_t    head,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output chan_t        out_red,
  output chan_t        out_green,
  output chan_t        out_blue,
  output logic         out_frame_last
);

  logic              b1_v_r, b1_last_r, o_v_r;
  logic [PROD_W-1:0] b1_red_r, b1_green_r, b1_blue_r;
  logic [RCP_W-1:0]  rcp;
  logic              adv_o, adv_b1;

  assign adv_o  = !o_v_r || out_ready;
  assign adv_b1 = !b1_v_r || adv_o;
  assign pop    = q_stat.valid & adv_b1;
  assign rcp    = recip(head.cnt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (adv_b1) begin
        b1_v_r <= q_stat.valid;
      end
      if (adv_o) begin
        o_v_r <= b1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b1) begin
      b1_red_r   <= PROD_W'(head.red) * PROD_W'(rcp);
      b1_green_r <= PROD_W'(head.green) * PROD_W'(rcp);
      b1_blue_r  <= PROD_W'(head.blue) * PROD_W'(rcp);
      b1_last_r  <= head.last;
    end
    if (adv_o) begin
      out_red        <= b1_red_r[RCP_SHIFT +: CH_W];
      out_green      <= b1_green_r[RCP_SHIFT +: CH_W];
      out_blue       <= b1_blue_r[RCP_SHIFT +: CH_W];
      out_frame_last <= b1_last_r;
    end
  end

  assign out_valid = o_v_r;

endmodule

`default_nettype wire

### sv/dilated_box_blur_3x3.sv
// top level of the dilated 3x3 box blur: front end, queue, back end
// depends on dbb_pkg, dbb_front, dbb_queue, dbb_back
//
//  channel  ports                                        direction
//  cfg      cfg_valid/cfg_ready, cfg_data                in, frame size
//  in       in_valid/in_ready, in_mode, in_red..blue     in, pixel or flush
//  out      out_valid/out_ready, out_red..blue, last     out, blurred pixel
//
// one transaction per cycle on the input side while in_ready is high; the path to a
// result runs through line store read, window and sum, queue, divide and output
// in_ready drops only in reset or if the 4-entry queue plus 2 feed stages would overflow
// synchronous active-low reset; line stores hold no reset
`default_nettype none

module dilated_box_blur_3x3
  import dbb_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_mode,
  input  wire chan_t            in_red,
  input  wire chan_t            in_green,
  input  wire chan_t            in_blue,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output chan_t                 out_red,
  output chan_t                 out_green,
  output chan_t                 out_blue,
  output logic                  out_frame_last
);

  logic    push_valid, pop;
  acc_t    push_data, head;
  q_stat_t q_stat;

  dbb_front #(.MAX_SIZE(MAX_SIZE)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .q_stat     (q_stat),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  dbb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .q_stat     (q_stat),
    .head       (head)
  );

  dbb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_frame_last (out_frame_last)
  );

endmodule

`default_nettype wire

### tb/sv/tb.sv
// self-checking testbench for the dilated 3x3 box blur
// depends on dbb_pkg and dilated_box_blur_3x3
`timescale 1ns / 1ps

module tb;
  import dbb_pkg::*;

  localparam int DEPTH   = 4 * MAX_SIZE_DEF + 8;
  localparam int WD_LIMIT = 20000;

  typedef struct {
    logic  mode;
    chan_t red;
    chan_t green;
    chan_t blue;
  } pix_in_t;

  typedef struct {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } blur_out_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid, in_ready, in_mode;
  chan_t in_red, in_green, in_blue;
  logic out_valid, out_ready;
  chan_t out_red, out_green, out_blue;
  logic out_frame_last;

  dilated_box_blur_3x3 dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_frame_last(out_frame_last)
  );

  // predictor state
  logic [PIX_W-1:0] line_mem [DEPTH];
  int unsigned size_reg;
  int unsigned src_row, src_col, dst_row, dst_col;
  blur_out_t blur_q[$];
  int errors;
  int idle_cycles;
  bit rx_hold;   // receiver held off for a long stretch
  bit calm;      // no random idling

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic int unsigned eff_n();
    if (size_reg < 1) return 1;
    if (size_reg > MAX_SIZE_DEF) return MAX_SIZE_DEF;
    return size_reg;
  endfunction

  function automatic void restart_frame();
    src_row = 0; src_col = 0; dst_row = 0; dst_col = 0;
  endfunction

  function automatic void blur_next(input int unsigned n);
    int unsigned sr, sg, sb, cnt, q;
    int rr, cc;
    logic [PIX_W-1:0] px;
    blur_out_t o;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int dr = -2; dr <= 2; dr += 2)
      for (int dc = -2; dc <= 2; dc += 2) begin
        rr = int'(dst_row) + dr;
        cc = int'(dst_col) + dc;
        if (rr < 0 || cc < 0 || rr >= int'(n) || cc >= int'(n)) continue;
        px = line_mem[(rr * n + cc) % DEPTH];
        sr += 32'(px[47:32]);
        sg += 32'(px[31:16]);
        sb += 32'(px[15:0]);
        cnt++;
      end
    if (cnt == 0) cnt = 1;
    q = dst_row * n + dst_col;
    o.red = chan_t'(sr / cnt);
    o.green = chan_t'(sg / cnt);
    o.blue = chan_t'(sb / cnt);
    o.last = (q == n * n - 1);
    blur_q.push_back(o);
    if (o.last) restart_frame();
    else begin
      dst_col++;
      if (dst_col >= n) begin
        dst_col = 0;
        dst_row++;
      end
    end
  endfunction

  function automatic void predict_pixel(input pix_in_t it);
    int unsigned n, p;
    n = eff_n();
    if (it.mode == MODE_PIXEL) begin
      if (src_row >= n) return;
      p = src_row * n + src_col;
      line_mem[p % DEPTH] = {it.red, it.green, it.blue};
      src_col++;
      if (src_col >= n) begin
        src_col = 0;
        src_row++;
      end
      if (p >= 2 * n + 2) blur_next(n);
    end else if (src_row >= n) begin
      blur_next(n);
    end
  endfunction

  // random stall on the receiver, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !rx_hold && (calm || $urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    blur_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (blur_q.size() == 0) begin
        report("unexpected result", 32'(out_red), 0);
      end else begin
        e = blur_q.pop_front();
        if (out_red !== e.red) report("red", 32'(out_red), 32'(e.red));
        if (out_green !== e.green) report("green", 32'(out_green), 32'(e.green));
        if (out_blue !== e.blue) report("blue", 32'(out_blue), 32'(e.blue));
        if (out_frame_last !== e.last)
          report("frame_last", 32'(out_frame_last), 32'(e.last));
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || rx_hold)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("dilated_box_blur_3x3 verification failed");
      $finish;
    end
  end

  // valid stays up between back-to-back transactions and drops only while idling
  task automatic send_item(input pix_in_t it);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= it.mode;
    in_red <= it.red;
    in_green <= it.green;
    in_blue <= it.blue;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blur_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    size_reg = 32'(v);
    restart_frame();
  endtask

  function automatic pix_in_t rand_pix(input logic mode);
    pix_in_t it;
    it.mode = mode;
    it.red = chan_t'($urandom);
    it.green = chan_t'($urandom);
    it.blue = chan_t'($urandom);
    return it;
  endfunction

  // full frame followed by flushes, with optional early flush or noise
  task automatic run_frame(input int unsigned n, input bit noisy);
    int unsigned total;
    total = n * n;
    for (int unsigned i = 0; i < total; i++) begin
      if (noisy && $urandom_range(19) == 0) send_item(rand_pix(MODE_FLUSH));
      send_item(rand_pix(MODE_PIXEL));
    end
    if (noisy) send_item(rand_pix(MODE_PIXEL));
    for (int unsigned i = 0; i < 2 * n + 2 && i < total; i++)
      send_item(rand_pix(MODE_FLUSH));
  endtask

  typedef struct {
    pix_in_t   px;
    bit        has_exp;
    blur_out_t want;
  } step_t;

  initial begin
    // size 1 frame: the single pixel is its own mean, with all-ones and all-zero channels
    step_t steps[] = '{
      '{'{MODE_FLUSH, 16'h1234, 16'h0, 16'h0}, 1'b0, '{0, 0, 0, 1'b0}},
      '{'{MODE_PIXEL, 16'hffff, 16'h0000, 16'h8001}, 1'b0, '{0, 0, 0, 1'b0}},
      '{'{MODE_PIXEL, 16'h5555, 16'h5555, 16'h5555}, 1'b0, '{0, 0, 0, 1'b0}},
      '{'{MODE_FLUSH, 16'h0, 16'h0, 16'h0}, 1'b1, '{16'hffff, 16'h0000, 16'h8001, 1'b1}},
      '{'{MODE_FLUSH, 16'h0, 16'h0, 16'h0}, 1'b0, '{0, 0, 0, 1'b0}},
      '{'{MODE_PIXEL, 16'h0000, 16'hffff, 16'h7ffe}, 1'b0, '{0, 0, 0, 1'b0}},
      '{'{MODE_FLUSH, 16'h0, 16'h0, 16'h0}, 1'b1, '{16'h0000, 16'hffff, 16'h7ffe, 1'b1}}
    };
    blur_out_t chk;
    int unsigned sizes[] = '{3, 5, 2, 7, 4, 0, 6};

    errors = 0;
    rx_hold = 1'b0;
    calm = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_mode = MODE_PIXEL;
    in_red = '0; in_green = '0; in_blue = '0;
    for (int i = 0; i < DEPTH; i++) line_mem[i] = '0;
    size_reg = 32'(FRAME_SIZE_RST);
    restart_frame();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_size(CFG_W'(1));
    foreach (steps[i]) begin
      send_item(steps[i].px);
      if (steps[i].has_exp) begin
        if (blur_q.size() == 0) begin
          report("table row missing", 32'(i), 0);
        end else begin
          chk = blur_q[blur_q.size() - 1];
          if (chk.red !== steps[i].want.red)
            report("table red", 32'(chk.red), 32'(steps[i].want.red));
          if (chk.green !== steps[i].want.green)
            report("table green", 32'(chk.green), 32'(steps[i].want.green));
          if (chk.blue !== steps[i].want.blue)
            report("table blue", 32'(chk.blue), 32'(steps[i].want.blue));
          if (chk.last !== steps[i].want.last)
            report("table frame_last", 32'(chk.last), 32'(steps[i].want.last));
        end
      end
    end

    // short frames over several sizes, including size zero clamped to one
    foreach (sizes[i]) begin
      write_size(CFG_W'(sizes[i]));
      run_frame(sizes[i] == 0 ? 1 : sizes[i], 1'(i % 2));
    end

    // receiver held off while the sender keeps offering: forces input stall
    write_size(CFG_W'(8));
    rx_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end
      run_frame(8, 0);
    join

    // a stretch with no idling anywhere
    calm = 1'b1;
    write_size(CFG_W'(9));
    run_frame(9, 0);
    calm = 1'b0;

    // random frames, restarting mid-frame now and then
    for (int k = 0; k < 12; k++) begin
      write_size(CFG_W'($urandom_range(2, 7)));
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 10)) send_item(rand_pix(1'($urandom_range(1))));
      else run_frame(eff_n(), 1'($urandom_range(1)));
    end

    // largest and above-range sizes: a partial frame then a restart
    write_size(CFG_W'(1024));
    repeat (40) send_item(rand_pix(MODE_PIXEL));
    write_size(CFG_W'(2047));
    repeat (40) send_item(rand_pix(MODE_PIXEL));
    // a wide frame run far enough to give its first results
    write_size(CFG_W'(200));
    repeat (420) send_item(rand_pix(MODE_PIXEL));
    write_size(FRAME_SIZE_RST);
    drain();

    if (errors == 0)
      $display("dilated_box_blur_3x3 verification clean");
    else
      $display("dilated_box_blur_3x3 verification failed");
    $finish;
  end

endmodule

### files.f
sv/dbb_pkg.sv
sv/dbb_front.sv
sv/dbb_queue.sv
sv/dbb_back.sv
sv/dilated_box_blur_3x3.sv
tb/sv/tb.sv
